### rtl/mi3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared constants for the 3x3 matrix inverter.
// ----------------------------------------------------------------------------
package mi3_pkg;

  // one lane per cofactor, lane k holds C(k/3, k%3)
  localparam int LANES = 9;

endpackage

### rtl/matrix3x3_inverse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// Pipelined 3x3 matrix inverse by the adjugate method, signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one whole matrix a00..a22 per
//   transfer; output channel out_valid/out_ready carries the inverse b00..b22
//   plus the singular flag. Elements are signed with FRAC_BITS fraction bits.
//   Each result element is the matching adjugate entry divided by the
//   determinant, rounded to nearest (ties away from zero) and saturated.
//   A zero determinant gives all-zero elements and singular = 1.
// Throughput: one matrix per cycle, sustained while out_ready is high.
// Pipeline: five stages of products, cofactors, determinant terms,
//   determinant sum and operand set-up, one range-check stage, then the
//   quotient, which takes one bit per stage in nine parallel restoring
//   dividers, and the output stage.
// Reset: rst (synchronous) empties every stage; no output is pending after.
// Stall: each stage moves on when it is empty or its successor moves, so a
//   stalled receiver only fills bubbles; in_ready drops once every stage holds
//   a matrix and out_ready is low. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module matrix3x3_inverse #(
  parameter int ELEM_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [ELEM_WIDTH-1:0] a00,
  input  logic signed [ELEM_WIDTH-1:0] a01,
  input  logic signed [ELEM_WIDTH-1:0] a02,
  input  logic signed [ELEM_WIDTH-1:0] a10,
  input  logic signed [ELEM_WIDTH-1:0] a11,
  input  logic signed [ELEM_WIDTH-1:0] a12,
  input  logic signed [ELEM_WIDTH-1:0] a20,
  input  logic signed [ELEM_WIDTH-1:0] a21,
  input  logic signed [ELEM_WIDTH-1:0] a22,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [ELEM_WIDTH-1:0] b00,
  output logic signed [ELEM_WIDTH-1:0] b01,
  output logic signed [ELEM_WIDTH-1:0] b02,
  output logic signed [ELEM_WIDTH-1:0] b10,
  output logic signed [ELEM_WIDTH-1:0] b11,
  output logic signed [ELEM_WIDTH-1:0] b12,
  output logic signed [ELEM_WIDTH-1:0] b20,
  output logic signed [ELEM_WIDTH-1:0] b21,
  output logic signed [ELEM_WIDTH-1:0] b22,
  output logic                         singular
);

  localparam int EW   = ELEM_WIDTH;
  localparam int NL   = mi3_pkg::LANES;
  localparam int PW   = 2 * EW;           // element product
  localparam int MW   = 2 * EW + 1;       // cofactor
  localparam int TW   = 3 * EW + 1;       // determinant term and sum
  localparam int CMW  = 2 * EW;           // |cofactor|
  localparam int DMW  = 3 * EW;           // |det|
  localparam int NUMW = 2 * EW + 2 * FRAC_BITS + 1;
  localparam int XW   = ((NUMW > DMW) ? NUMW : DMW) + 1;  // dividend / remainder
  localparam int NST  = EW + 7;           // total register stages

  // stage map: 0 products, 1 cofactors, 2 det terms, 3 det sum, 4 operands,
  // 5 range check, 6..5+EW quotient bits, 6+EW output
  logic [NST-1:0] v;
  logic [NST-1:0] en;

  // a stage moves when any stage from it to the output is empty, or the
  // receiver takes the result
  always_comb begin
    for (int s = 0; s < NST; s++) begin
      en[s] = out_ready || (((~v) >> s) != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int s = 1; s < NST; s++) begin
        if (en[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NST-1];

  // ---- stage 0: the eighteen element products, C(k) = pa(k) - pb(k) ----
  logic signed [EW-1:0] ma [NL];
  logic signed [EW-1:0] mb [NL];
  logic signed [EW-1:0] mc [NL];
  logic signed [EW-1:0] md [NL];

  always_comb begin
    ma[0] = a11; mb[0] = a22; mc[0] = a12; md[0] = a21;
    ma[1] = a12; mb[1] = a20; mc[1] = a10; md[1] = a22;
    ma[2] = a10; mb[2] = a21; mc[2] = a11; md[2] = a20;
    ma[3] = a02; mb[3] = a21; mc[3] = a01; md[3] = a22;
    ma[4] = a00; mb[4] = a22; mc[4] = a02; md[4] = a20;
    ma[5] = a01; mb[5] = a20; mc[5] = a00; md[5] = a21;
    ma[6] = a01; mb[6] = a12; mc[6] = a02; md[6] = a11;
    ma[7] = a02; mb[7] = a10; mc[7] = a00; md[7] = a12;
    ma[8] = a00; mb[8] = a11; mc[8] = a01; md[8] = a10;
  end

  logic signed [PW-1:0] pa [NL];
  logic signed [PW-1:0] pb [NL];
  logic signed [EW-1:0] r0_s0 [3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int l = 0; l < NL; l++) begin
        pa[l] <= PW'(ma[l]) * PW'(mb[l]);
        pb[l] <= PW'(mc[l]) * PW'(md[l]);
      end
      r0_s0[0] <= a00;
      r0_s0[1] <= a01;
      r0_s0[2] <= a02;
    end
  end

  // ---- stage 1: cofactors ----
  logic signed [MW-1:0] cof1 [NL];
  logic signed [EW-1:0] r0_s1 [3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int l = 0; l < NL; l++) begin
        cof1[l] <= MW'(pa[l]) - MW'(pb[l]);
      end
      r0_s1 <= r0_s0;
    end
  end

  // ---- stage 2: Laplace terms along row 0 ----
  logic signed [MW-1:0] cof2 [NL];
  logic signed [TW-1:0] dterm [3];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      cof2 <= cof1;
      for (int j = 0; j < 3; j++) begin
        dterm[j] <= TW'(r0_s1[j]) * TW'(cof1[j]);
      end
    end
  end

  // ---- stage 3: determinant ----
  logic signed [MW-1:0] cof3 [NL];
  logic signed [TW-1:0] det3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      cof3 <= cof2;
      det3 <= dterm[0] + dterm[1] + dterm[2];
    end
  end

  // ---- stage 4: divider operands, X = 2|C|<<2F + |det|, D = 2|det| ----
  logic signed [TW-1:0] det_neg;
  logic [DMW-1:0]       dmag;

  assign det_neg = -det3;
  assign dmag    = det3[TW-1] ? det_neg[DMW-1:0] : det3[DMW-1:0];

  logic [XW-1:0] x4 [NL];
  logic [XW-1:0] d4;
  logic [NL-1:0] neg4;
  logic          sing4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int l = 0; l < NL; l++) begin
        logic signed [MW-1:0] cn;
        logic [CMW-1:0]       cm;
        cn = -cof3[l];
        cm = cof3[l][MW-1] ? cn[CMW-1:0] : cof3[l][CMW-1:0];
        x4[l]   <= (XW'(cm) << (2 * FRAC_BITS + 1)) + XW'(dmag);
        neg4[l] <= cof3[l][MW-1] ^ det3[TW-1];
      end
      d4    <= XW'(dmag) << 1;
      sing4 <= (det3 == '0);
    end
  end

  // ---- stage 5 onward: range check, then one quotient bit per stage ----
  logic [XW-1:0] rem  [EW+1][NL];
  logic [EW-1:0] quo  [EW+1][NL];
  logic [NL-1:0] ovf  [EW+1];
  logic [NL-1:0] neg  [EW+1];
  logic [XW-1:0] den  [EW+1];
  logic          sing [EW+1];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int l = 0; l < NL; l++) begin
        rem[0][l] <= x4[l];
        quo[0][l] <= '0;
        ovf[0][l] <= ((XW+EW)'(x4[l]) >= ((XW+EW)'(d4) << EW));
      end
      neg[0]  <= neg4;
      den[0]  <= d4;
      sing[0] <= sing4;
    end
    // stage 5+t settles quotient bit EW-t
    for (int t = 1; t <= EW; t++) begin
      if (en[5+t]) begin
        for (int l = 0; l < NL; l++) begin
          if ((rem[t-1][l] >> (EW - t)) >= den[t-1]) begin
            rem[t][l] <= rem[t-1][l] - (den[t-1] << (EW - t));
            quo[t][l] <= quo[t-1][l] | (EW'(1) << (EW - t));
          end else begin
            rem[t][l] <= rem[t-1][l];
            quo[t][l] <= quo[t-1][l];
          end
        end
        ovf[t]  <= ovf[t-1];
        neg[t]  <= neg[t-1];
        den[t]  <= den[t-1];
        sing[t] <= sing[t-1];
      end
    end
  end

  // ---- output stage: sign, saturation, singular override ----
  localparam logic [EW:0] MAXMAG = {2'b00, {(EW-1){1'b1}}};
  localparam logic [EW:0] MINMAG = {2'b01, {(EW-1){1'b0}}};

  logic signed [EW-1:0] bo [NL];
  logic                 sing_o;

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      for (int l = 0; l < NL; l++) begin
        logic [EW:0] qm;
        logic [EW:0] qn;
        qm = ovf[EW][l] ? {1'b1, EW'(0)} : {1'b0, quo[EW][l]};
        qn = -qm;
        if (sing[EW]) begin
          bo[l] <= '0;
        end else if (neg[EW][l]) begin
          bo[l] <= (qm > MINMAG) ? MINMAG[EW-1:0] : qn[EW-1:0];
        end else begin
          bo[l] <= (qm > MAXMAG) ? MAXMAG[EW-1:0] : qm[EW-1:0];
        end
      end
      sing_o <= sing[EW];
    end
  end

  // b(i,j) is cofactor C(j,i): transpose the lanes
  assign b00 = bo[0];
  assign b01 = bo[3];
  assign b02 = bo[6];
  assign b10 = bo[1];
  assign b11 = bo[4];
  assign b12 = bo[7];
  assign b20 = bo[2];
  assign b21 = bo[5];
  assign b22 = bo[8];
  assign singular = sing_o;

  // ---- checks ----
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> (b00 == '0) && (b11 == '0) && (b22 == '0)
                              && (b01 == '0) && (b12 == '0) && (b20 == '0))
    else $error("singular result with non-zero elements");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input held off without a stalled full pipeline");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v[0])
    else $error("accepted matrix not held in first stage");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("pending result dropped");

endmodule
